/* src/mqrb_pkg.sv */
package mqrb_pkg;

	localparam int NUM_QUEUES  = 8;
	localparam int QUEUE_DEPTH = 256;

	localparam int WORD_W  = 32;
	localparam int OFF_W   = 8;
	localparam int QIN_W   = 3;
	localparam int OCC_W   = 9;
	localparam int QSEL_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int PTR_W   = $clog2(QUEUE_DEPTH);
	localparam int TOTAL   = NUM_QUEUES * QUEUE_DEPTH;
	localparam int ADDR_W  = $clog2(TOTAL);
	localparam int CMP_W   = ((PTR_W > OFF_W) ? PTR_W : OFF_W) + 1;

	localparam logic [WORD_W-1:0] HEAD_SKIP_WORD = 32'hffff_ffff;

	typedef enum logic [2:0] {
		OP_ENQ       = 3'd0,
		OP_DEQ       = 3'd1,
		OP_PEEK      = 3'd2,
		OP_COUNT     = 3'd3,
		OP_MODIFY    = 3'd4,
		OP_RESET_Q   = 3'd5,
		OP_RESET_ALL = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_WRAP   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_ZOMBIE = 2'd3
	} status_t;

	// decoded work for one item, handed from the pointer stage to the store stage
	typedef struct packed {
		logic              rd_word;
		logic              wr_en;
		logic              is_mod;
		logic [ADDR_W-1:0] addr;
		logic [WORD_W-1:0] data;
		logic [WORD_W-1:0] mask;
		logic [OCC_W-1:0]  occ;
		status_t           status;
	} cmd_t;

endpackage

/* src/mqrb_ram.sv */
module mqrb_ram
	import mqrb_pkg::*;
(
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WORD_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WORD_W-1:0] rd_data
);

	logic [WORD_W-1:0] mem [TOTAL];
	logic [WORD_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* src/mqrb_ptr.sv */
module mqrb_ptr
	import mqrb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              zombies_ctl,
	input  logic [2:0]        operation,
	input  logic [QIN_W-1:0]  queue_index,
	input  logic              queue_is_zombie,
	input  logic [WORD_W-1:0] data_word,
	input  logic [WORD_W-1:0] bit_mask,
	input  logic [OFF_W-1:0]  peek_offset,
	output cmd_t              cmd
);

	localparam logic [PTR_W-1:0] DEPTH_M1 = PTR_W'(QUEUE_DEPTH - 1);

	logic [PTR_W-1:0] rp_q [NUM_QUEUES];
	logic [PTR_W-1:0] wp_q [NUM_QUEUES];

	logic [QSEL_W-1:0] q_sel;
	logic              q_ok;
	logic              zblock;
	logic [PTR_W-1:0]  rp, wp, rp_inc, wp_inc, occ, peek_idx;
	logic [CMP_W-1:0]  off_ext, occ_ext, peek_sum;
	logic              rp_we, wp_we, clr_all;
	logic [PTR_W-1:0]  rp_new, wp_new;
	op_t               op;

	function automatic logic [ADDR_W-1:0] slot_addr(input logic [QSEL_W-1:0] qs,
			input logic [PTR_W-1:0] idx);
		slot_addr = ADDR_W'(ADDR_W'(qs) * ADDR_W'(QUEUE_DEPTH)) + ADDR_W'(idx);
	endfunction

	assign op     = op_t'(operation);
	assign q_sel  = QSEL_W'(queue_index);
	assign q_ok   = (32'(queue_index) < NUM_QUEUES);
	assign zblock = queue_is_zombie && !zombies_ctl;
	assign rp     = rp_q[q_sel];
	assign wp     = wp_q[q_sel];
	assign rp_inc = (rp == DEPTH_M1) ? '0 : rp + 1'b1;
	assign wp_inc = (wp == DEPTH_M1) ? '0 : wp + 1'b1;
	assign occ    = (wp >= rp) ? (wp - rp) : PTR_W'(CMP_W'(wp) + CMP_W'(QUEUE_DEPTH) - CMP_W'(rp));

	assign off_ext  = CMP_W'(peek_offset);
	assign occ_ext  = CMP_W'(occ);
	assign peek_sum = CMP_W'(rp) + off_ext;
	assign peek_idx = (peek_sum >= CMP_W'(QUEUE_DEPTH)) ?
		PTR_W'(peek_sum - CMP_W'(QUEUE_DEPTH)) : PTR_W'(peek_sum);

	always_comb begin
		cmd        = '0;
		cmd.status = ST_OK;
		cmd.data   = data_word;
		cmd.mask   = bit_mask;
		cmd.addr   = slot_addr(q_sel, rp);
		rp_we      = 1'b0;
		wp_we      = 1'b0;
		rp_new     = rp;
		wp_new     = wp;
		clr_all    = 1'b0;
		if (op == OP_RESET_ALL) begin
			clr_all = 1'b1;
		end else if (!q_ok) begin
			cmd.status = ST_EMPTY;
		end else begin
			case (op)
				OP_ENQ: begin
					if (zblock) begin
						cmd.status = ST_ZOMBIE;
					end else begin
						cmd.wr_en = 1'b1;
						cmd.addr  = slot_addr(q_sel, wp);
						wp_we     = 1'b1;
						wp_new    = wp_inc;
						if (wp_inc == rp) begin
							cmd.status = ST_WRAP;
						end
					end
				end
				OP_DEQ: begin
					if (zblock) begin
						cmd.status = ST_ZOMBIE;
					end else if (rp == wp) begin
						cmd.status = ST_EMPTY;
					end else begin
						cmd.rd_word = 1'b1;
						rp_we       = 1'b1;
						rp_new      = rp_inc;
					end
				end
				OP_PEEK: begin
					if (zblock) begin
						cmd.status = ST_ZOMBIE;
					end else if (off_ext >= occ_ext) begin
						cmd.status = ST_EMPTY;
					end else begin
						cmd.rd_word = 1'b1;
						cmd.addr    = slot_addr(q_sel, peek_idx);
					end
				end
				OP_COUNT: begin
					if (zblock) begin
						cmd.occ    = OCC_W'(QUEUE_DEPTH);
						cmd.status = ST_ZOMBIE;
					end else begin
						cmd.occ = OCC_W'(occ);
					end
				end
				OP_MODIFY: begin
					// a blocked zombie sees a full queue, so its head modify is always issued
					if (!zblock && occ == '0) begin
						cmd.status = ST_EMPTY;
					end else begin
						cmd.wr_en  = 1'b1;
						cmd.is_mod = 1'b1;
					end
				end
				OP_RESET_Q: begin
					rp_we  = 1'b1;
					wp_we  = 1'b1;
					rp_new = '0;
					wp_new = '0;
				end
				default: begin
					cmd.status = ST_EMPTY;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				rp_q[i] <= '0;
				wp_q[i] <= '0;
			end
		end else if (accept) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				if (clr_all) begin
					rp_q[i] <= '0;
					wp_q[i] <= '0;
				end else if (QSEL_W'(i) == q_sel) begin
					if (rp_we) rp_q[i] <= rp_new;
					if (wp_we) wp_q[i] <= wp_new;
				end
			end
		end
	end

	a_wrap_is_enq: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.status == ST_WRAP |-> cmd.wr_en && !cmd.is_mod)
		else $error("overflow flagged without a plain enqueue write");
	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.rd_word |-> cmd.status == ST_OK && !cmd.wr_en)
		else $error("store read issued with a failing status");
	a_occ_count_only: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.occ != '0 |-> op == OP_COUNT)
		else $error("occupancy reported by an operation other than count");

endmodule

/* src/multi_queue_ring_buffer.sv */
// Pipeline: pointer decode ahead of the input register, then registered store read
// into the result register, with masked read-modify-write back to the store.
// Throughput: one item per cycle unless m_tready back-pressure or the store clear
// stalls it, held by the single store write port.
// Reset: pointers and config clear at once; the store is then swept to zero, one
// word a cycle, NUM_QUEUES * QUEUE_DEPTH = 2048 words with s_tready low.
module multi_queue_ring_buffer
	import mqrb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,   // zombies_controllable
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,       // data_word[31:0], bit_mask[63:32], peek_offset[71:64]
	input  logic [6:0]  s_tuser,       // operation[2:0], queue_index[5:3], queue_is_zombie[6]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,       // read_word[31:0], occupancy[40:32], zero[47:41]
	output logic [1:0]  m_tuser        // status[1:0]
);

	logic              zombies_ctl_q;
	logic              clear_busy_q;
	logic [ADDR_W-1:0] clr_addr_q;

	logic              accept, adv;
	cmd_t              cmd;
	cmd_t              cmd_s1;
	logic              s1_valid_q;
	logic              fwd_hit_s1;
	logic [WORD_W-1:0] fwd_word_s1;

	logic [WORD_W-1:0] ram_rdata, head_s1, wr_word_s1;
	logic              s1_wr_fire;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [WORD_W-1:0] ram_wdata;

	logic              m_tvalid_q;
	logic [WORD_W-1:0] read_word_q;
	logic [OCC_W-1:0]  occ_q;
	status_t           status_q;

	assign adv      = !m_tvalid_q || m_tready;
	assign s_tready = !clear_busy_q && (!s1_valid_q || adv);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zombies_ctl_q <= 1'b0;
		end else if (cfg_wr_en) begin
			zombies_ctl_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_busy_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clear_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_W'(TOTAL - 1)) begin
				clear_busy_q <= 1'b0;
			end
		end
	end

	mqrb_ptr u_ptr (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.zombies_ctl     (zombies_ctl_q),
		.operation       (s_tuser[2:0]),
		.queue_index     (s_tuser[5:3]),
		.queue_is_zombie (s_tuser[6]),
		.data_word       (s_tdata[31:0]),
		.bit_mask        (s_tdata[63:32]),
		.peek_offset     (s_tdata[71:64]),
		.cmd             (cmd)
	);

	// head word: store data unless the item ahead wrote the same word on the read edge
	assign head_s1    = fwd_hit_s1 ? fwd_word_s1 : ram_rdata;
	assign wr_word_s1 = cmd_s1.is_mod ?
		((head_s1 & ~cmd_s1.mask) | (cmd_s1.data & cmd_s1.mask)) : cmd_s1.data;
	assign s1_wr_fire = s1_valid_q && adv && cmd_s1.wr_en &&
		(!cmd_s1.is_mod || head_s1 != HEAD_SKIP_WORD);

	assign ram_we    = clear_busy_q || s1_wr_fire;
	assign ram_waddr = clear_busy_q ? clr_addr_q : cmd_s1.addr;
	assign ram_wdata = clear_busy_q ? '0 : wr_word_s1;

	mqrb_ram u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (accept),
		.rd_addr (cmd.addr),
		.rd_data (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1      <= cmd;
			fwd_hit_s1  <= s1_wr_fire && (cmd_s1.addr == cmd.addr);
			fwd_word_s1 <= wr_word_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s1_valid_q) begin
			read_word_q <= cmd_s1.rd_word ? head_s1 : '0;
			occ_q       <= cmd_s1.occ;
			status_q    <= cmd_s1.status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'b0, occ_q, read_word_q};
	assign m_tuser  = status_q;

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clear_busy_q |-> !s_tready)
		else $error("item accepted during store clear");
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(clear_busy_q && s1_wr_fire))
		else $error("clear sweep and item write collide");
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> s1_valid_q)
		else $error("accepted item missing from store stage");

endmodule

/* verif/mqrb_result_checker.sv */
`timescale 1ns / 1ps
module mqrb_result_checker
	import mqrb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [71:0] s_tdata,
	input  logic [6:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	input  logic [1:0]  m_tuser,
	output int          fail_count,
	output int          outstanding,
	output int          results_checked,
	output int          wraps_seen,
	output int          zombie_blocks
);

	typedef struct {
		logic [WORD_W-1:0] word;
		logic [OCC_W-1:0]  occ;
		status_t           status;
	} queue_reply_t;

	logic [WORD_W-1:0] word_mem [TOTAL];
	int unsigned       head_idx [NUM_QUEUES];
	int unsigned       tail_idx [NUM_QUEUES];
	logic              zombies_free;
	queue_reply_t      awaited [$];

	function automatic queue_reply_t apply_queue_op(input logic [2:0] op, input int unsigned q,
			input logic zombie, input logic [WORD_W-1:0] data, input logic [WORD_W-1:0] mask,
			input logic [OFF_W-1:0] off);
		queue_reply_t r;
		logic         blocked;
		int unsigned  used;
		int unsigned  head;
		r.word   = '0;
		r.occ    = '0;
		r.status = ST_OK;
		blocked  = zombie && !zombies_free;
		if (op == OP_RESET_ALL) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head_idx[i] = 0;
				tail_idx[i] = 0;
			end
		end else if (q >= NUM_QUEUES) begin
			r.status = ST_EMPTY;
		end else begin
			used = (QUEUE_DEPTH + tail_idx[q] - head_idx[q]) % QUEUE_DEPTH;
			head = q * QUEUE_DEPTH + head_idx[q];
			case (op)
			OP_ENQ: begin
				if (blocked) begin
					r.status = ST_ZOMBIE;
				end else begin
					word_mem[q * QUEUE_DEPTH + tail_idx[q]] = data;
					tail_idx[q] = (tail_idx[q] + 1) % QUEUE_DEPTH;
					if (tail_idx[q] == head_idx[q])
						r.status = ST_WRAP;
				end
			end
			OP_DEQ: begin
				if (blocked) begin
					r.status = ST_ZOMBIE;
				end else if (used == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.word = word_mem[head];
					head_idx[q] = (head_idx[q] + 1) % QUEUE_DEPTH;
				end
			end
			OP_PEEK: begin
				if (blocked)
					r.status = ST_ZOMBIE;
				else if (off >= used)
					r.status = ST_EMPTY;
				else
					r.word = word_mem[q * QUEUE_DEPTH + (head_idx[q] + off) % QUEUE_DEPTH];
			end
			OP_COUNT: begin
				if (blocked) begin
					r.occ    = OCC_W'(QUEUE_DEPTH);
					r.status = ST_ZOMBIE;
				end else begin
					r.occ = OCC_W'(used);
				end
			end
			OP_MODIFY: begin
				// zombie modify is not blocked: it sees a full queue
				if (!blocked && used == 0)
					r.status = ST_EMPTY;
				else if (word_mem[head] != HEAD_SKIP_WORD)
					word_mem[head] = (word_mem[head] & ~mask) | (data & mask);
			end
			OP_RESET_Q: begin
				head_idx[q] = 0;
				tail_idx[q] = 0;
			end
			default: begin
				r.status = ST_EMPTY;
			end
			endcase
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		queue_reply_t      want;
		logic [WORD_W-1:0] got_word;
		logic [OCC_W-1:0]  got_occ;
		logic [6:0]        got_pad;
		if (!arst_n) begin
			for (int i = 0; i < TOTAL; i++)
				word_mem[i] = '0;
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head_idx[i] = 0;
				tail_idx[i] = 0;
			end
			zombies_free = 1'b0;
			awaited.delete();
			fail_count      = 0;
			outstanding     = 0;
			results_checked = 0;
			wraps_seen      = 0;
			zombie_blocks   = 0;
		end else begin
			if (cfg_wr_en)
				zombies_free = cfg_wr_data;
			if (m_tvalid && m_tready) begin
				got_word = m_tdata[WORD_W-1:0];
				got_occ  = m_tdata[WORD_W +: OCC_W];
				got_pad  = m_tdata[47:WORD_W+OCC_W];
				if (awaited.size() == 0) begin
					$error("unexpected result: read_word %h occupancy %0d status %0d",
						got_word, got_occ, m_tuser);
					fail_count++;
				end else begin
					want = awaited.pop_front();
					results_checked++;
					if (got_word !== want.word) begin
						$error("read_word mismatch: expected %h, got %h", want.word, got_word);
						fail_count++;
					end
					if (got_occ !== want.occ) begin
						$error("occupancy mismatch: expected %0d, got %0d", want.occ, got_occ);
						fail_count++;
					end
					if (got_pad !== '0) begin
						$error("pad mismatch: expected 0, got %h", got_pad);
						fail_count++;
					end
					if (m_tuser !== want.status) begin
						$error("status mismatch: expected %0d, got %0d", want.status, m_tuser);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				want = apply_queue_op(s_tuser[2:0], 32'(s_tuser[5:3]), s_tuser[6],
					s_tdata[31:0], s_tdata[63:32], s_tdata[71:64]);
				if (want.status == ST_WRAP)
					wraps_seen++;
				if (want.status == ST_ZOMBIE)
					zombie_blocks++;
				awaited.push_back(want);
			end
			outstanding = awaited.size();
		end
	end

endmodule

/* verif/tb_multi_queue_ring_buffer.sv */
`timescale 1ns / 1ps
module tb_multi_queue_ring_buffer;
	import mqrb_pkg::*;

	localparam logic [2:0] OP_UNUSED      = 3'd7;
	localparam int         PHASES         = 6;
	localparam int         PHASE_ITEMS    = 265;
	localparam int         RESULT_LATENCY = 2;
	localparam int         QUIET_LIMIT    = 10000;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic        cfg_wr_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic [6:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;

	int fail_count;
	int outstanding;
	int results_checked;
	int wraps_seen;
	int zombie_blocks;

	int n_sent;
	bit calm;
	int quiet_cycles;
	int stall_left;
	int cyc;
	bit phase_cfg [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

	multi_queue_ring_buffer DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

	mqrb_result_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.fail_count     (fail_count),
		.outstanding    (outstanding),
		.results_checked(results_checked),
		.wraps_seen     (wraps_seen),
		.zombie_blocks  (zombie_blocks)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// result side back-pressure in bursts, with stall-free stretches
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (calm || (cyc % 512) >= 320) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else if ($urandom_range(0, 11) == 0) begin
			stall_left <= $urandom_range(0, 17);
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [WORD_W-1:0] rand_word();
		case ($urandom_range(0, 7))
		0: return '0;
		1: return HEAD_SKIP_WORD;
		default: return $urandom;
		endcase
	endfunction

	// called at a rising edge; returns at the edge that accepts the item
	task automatic send_op(input logic [2:0] op, input int q, input logic zombie,
			input logic [WORD_W-1:0] data, input logic [WORD_W-1:0] mask,
			input logic [OFF_W-1:0] off);
		if (!calm && (n_sent % 300) < 200 && $urandom_range(0, 9) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {off, mask, data};
		s_tuser  <= {zombie, QIN_W'(q), op};
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		@(posedge clk);
		n_sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (RESULT_LATENCY + 2) @(posedge clk);
	endtask

	task automatic random_op(input int focus);
		logic [2:0] op;
		int         pick;
		int         q;
		pick = $urandom_range(0, 99);
		if (pick < 34)
			op = OP_ENQ;
		else if (pick < 56)
			op = OP_DEQ;
		else if (pick < 70)
			op = OP_PEEK;
		else if (pick < 79)
			op = OP_COUNT;
		else if (pick < 92)
			op = OP_MODIFY;
		else if (pick < 96)
			op = OP_RESET_Q;
		else if (pick < 98)
			op = OP_RESET_ALL;
		else
			op = OP_UNUSED;
		q = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NUM_QUEUES - 1) : focus;
		send_op(op, q, $urandom_range(0, 9) == 0, rand_word(), rand_word(),
			OFF_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 5)));
	endtask

	// enqueue a few, look inside, then take some back out
	task automatic queue_burst(input int q);
		int k;
		k = $urandom_range(1, 12);
		repeat (k)
			send_op(OP_ENQ, q, $urandom_range(0, 15) == 0, rand_word(), $urandom,
				OFF_W'($urandom));
		repeat ($urandom_range(0, 3))
			send_op(OP_PEEK, q, 1'b0, $urandom, $urandom, OFF_W'($urandom_range(0, k)));
		if ($urandom_range(0, 2) == 0)
			send_op(OP_MODIFY, q, 1'b0, rand_word(), rand_word(), OFF_W'($urandom));
		send_op(OP_COUNT, q, 1'b0, $urandom, $urandom, OFF_W'($urandom));
		repeat ($urandom_range(0, k + 1))
			send_op(OP_DEQ, q, 1'b0, $urandom, $urandom, OFF_W'($urandom));
	endtask

	// fill one queue to the brim, probe the far end, then wrap it
	task automatic fill_to_wrap(input int q);
		send_op(OP_RESET_Q, q, 1'b0, $urandom, $urandom, OFF_W'($urandom));
		repeat (QUEUE_DEPTH - 1)
			send_op(OP_ENQ, q, 1'b0, $urandom, $urandom, OFF_W'($urandom));
		send_op(OP_PEEK, q, 1'b0, $urandom, $urandom, OFF_W'(QUEUE_DEPTH - 2));
		send_op(OP_PEEK, q, 1'b0, $urandom, $urandom, OFF_W'(QUEUE_DEPTH - 1));
		send_op(OP_COUNT, q, 1'b0, $urandom, $urandom, OFF_W'($urandom));
		send_op(OP_ENQ, q, 1'b0, $urandom, $urandom, OFF_W'($urandom));
		send_op(OP_COUNT, q, 1'b0, $urandom, $urandom, OFF_W'($urandom));
		send_op(OP_DEQ, q, 1'b0, $urandom, $urandom, OFF_W'($urandom));
	endtask

	initial begin
		int focus;
		int start;
		bit filled;
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = '0;
		m_tready    = 1'b0;
		calm        = 1'b0;
		n_sent      = 0;
		cyc         = 0;
		stall_left  = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed, zombie control still at its reset value
		send_op(OP_COUNT,  0, 1'b0, '0, '0, '0);
		send_op(OP_DEQ,    0, 1'b0, '0, '0, '0);
		send_op(OP_PEEK,   0, 1'b0, '0, '0, '0);
		send_op(OP_MODIFY, 0, 1'b0, '0, HEAD_SKIP_WORD, '0);
		send_op(OP_ENQ,    0, 1'b0, HEAD_SKIP_WORD, '0, 8'hff);
		send_op(OP_ENQ,    0, 1'b0, '0, HEAD_SKIP_WORD, '0);
		send_op(OP_MODIFY, 0, 1'b0, '0, HEAD_SKIP_WORD, '0);
		send_op(OP_PEEK,   0, 1'b0, '0, '0, 8'd1);
		send_op(OP_DEQ,    0, 1'b0, '0, '0, '0);
		send_op(OP_MODIFY, 0, 1'b0, HEAD_SKIP_WORD, 32'ha5a5_a5a5, '0);
		send_op(OP_PEEK,   0, 1'b0, '0, '0, '0);
		send_op(OP_PEEK,   0, 1'b0, '0, '0, 8'hff);
		send_op(OP_ENQ,    7, 1'b1, 32'h1234_5678, '0, '0);
		send_op(OP_DEQ,    7, 1'b1, '0, '0, '0);
		send_op(OP_PEEK,   7, 1'b1, '0, '0, '0);
		send_op(OP_COUNT,  7, 1'b1, '0, '0, '0);
		send_op(OP_MODIFY, 7, 1'b1, 32'h5a5a_5a5a, 32'h0ff0_0ff0, '0);
		send_op(OP_ENQ,    7, 1'b0, 32'h8000_0001, '0, '0);
		send_op(OP_UNUSED, 3, 1'b0, HEAD_SKIP_WORD, HEAD_SKIP_WORD, 8'hff);
		send_op(OP_RESET_Q, 0, 1'b0, '0, '0, '0);
		send_op(OP_COUNT,  0, 1'b0, '0, '0, '0);
		send_op(OP_ENQ,    3, 1'b0, 32'hcafe_f00d, '0, '0);
		send_op(OP_RESET_ALL, 5, 1'b1, '0, '0, '0);
		send_op(OP_COUNT,  3, 1'b0, '0, '0, '0);
		send_op(OP_DEQ,    7, 1'b0, '0, '0, '0);

		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			cfg_wr_en   <= 1'b1;
			cfg_wr_data <= phase_cfg[p];
			@(posedge clk);
			cfg_wr_en <= 1'b0;
			calm   = (p == PHASES - 1);
			focus  = $urandom_range(0, NUM_QUEUES - 1);
			start  = n_sent;
			filled = 1'b0;
			while (n_sent - start < PHASE_ITEMS) begin
				if ((p == 1 || p == 4) && !filled && n_sent - start > 60) begin
					fill_to_wrap(focus);
					filled = 1'b1;
				end else if ($urandom_range(0, 2) == 0) begin
					random_op(focus);
				end else begin
					queue_burst(focus);
				end
				if ($urandom_range(0, 39) == 0)
					focus = $urandom_range(0, NUM_QUEUES - 1);
			end
		end

		wait_drained();
		$display("Sent %0d items over %0d zombie-control settings, %0d results checked.",
			n_sent, PHASES + 1, results_checked);
		$display("Overflow wraps: %0d, zombie-blocked items: %0d.", wraps_seen, zombie_blocks);
		if (fail_count == 0 && outstanding == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
